### rtl/tbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types and constants for the token bucket shaper.
// ----------------------------------------------------------------------------
package tbs_pkg;

    localparam int unsigned ID_W             = 16;
    localparam int unsigned TOK_W            = 16;
    localparam int unsigned QUEUE_DEPTH_DEF  = 64;
    localparam logic [TOK_W-1:0] BUCKET_DEPTH_RST = TOK_W'(10);

    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_ARRIVAL = 1'b1;

    typedef enum logic [1:0] {
        DROP_NONE    = 2'd0,
        DROP_EXCEEDS = 2'd1,
        DROP_FULL    = 2'd2
    } t_drop_code;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [TOK_W-1:0] cost;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

endpackage

`default_nettype wire

### rtl/tbs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbs_queue
// Waiting-packet FIFO in a synchronous memory; head entry prefetched into a
// register, with write forwarding when the new head is being written.
// ----------------------------------------------------------------------------
module tbs_queue #(
    parameter int unsigned QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF,
    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH),
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  tbs_pkg::t_q_ctrl    i_ctrl,
    input  tbs_pkg::t_entry     i_entry,
    output tbs_pkg::t_entry     o_head,
    output logic [CNT_W-1:0]    o_count
);

    tbs_pkg::t_entry r_mem [QUEUE_DEPTH];
    tbs_pkg::t_entry r_rd_data;
    tbs_pkg::t_entry r_fwd_data;
    logic            r_fwd;
    logic [PTR_W-1:0] r_head_ptr, n_head_ptr;
    logic [PTR_W-1:0] r_tail_ptr, n_tail_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_head_ptr = i_ctrl.pop  ? ptr_inc(r_head_ptr) : r_head_ptr;
        n_tail_ptr = i_ctrl.push ? ptr_inc(r_tail_ptr) : r_tail_ptr;
        n_count    = r_count + CNT_W'(i_ctrl.push) - CNT_W'(i_ctrl.pop);
    end

    // empty queue: an arriving item is its own head
    assign o_head  = (r_count == '0) ? i_entry : (r_fwd ? r_fwd_data : r_rd_data);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail_ptr] <= i_entry;
        end
        r_rd_data  <= r_mem[n_head_ptr];
        r_fwd_data <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_ptr <= '0;
            r_tail_ptr <= '0;
            r_count    <= '0;
            r_fwd      <= 1'b0;
        end else begin
            r_head_ptr <= n_head_ptr;
            r_tail_ptr <= n_tail_ptr;
            r_count    <= n_count;
            r_fwd      <= i_ctrl.push && (r_tail_ptr == n_head_ptr);
        end
    end

endmodule

`default_nettype wire

### rtl/token_bucket_shaper_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// token_bucket_shaper_core
// Token bucket shaper with a queue of waiting packets.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one event per item: a token
// tick or a packet arrival. Output channel (o_out_valid / i_out_ready) returns
// exactly one result item per input item, in order.
// Throughput: one item per cycle while o_in_ready is high. The queue head is
// read from memory ahead of use, so back-to-back arrivals and releases run
// without bubbles; the compare-subtract on the token count and the head read
// address are both combinational.
// Output: the result is registered in r_out, or held in r_skid while stalled.
// Stall: a skid register holds one further result; o_in_ready drops only
// when both output register and skid register are full.
// Reset: token count, queue pointers and count clear, bucket depth returns
// to 10, output channel empties. Queue memory is not cleared; only written
// entries are ever read. No clearing pass; items are taken once reset ends.
// i_cfg_we writes the bucket depth at once; write only while idle.
// ----------------------------------------------------------------------------
module token_bucket_shaper_core #(
    parameter int unsigned QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF,
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [tbs_pkg::TOK_W-1:0]   i_cfg_wdata,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire                        i_func,
    input  wire [tbs_pkg::ID_W-1:0]    i_packet_id,
    input  wire [tbs_pkg::TOK_W-1:0]   i_tokens_required,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic                       o_token_dropped,
    output logic [1:0]                 o_drop_code,
    output logic                       o_released,
    output logic [tbs_pkg::ID_W-1:0]   o_released_id,
    output logic [tbs_pkg::TOK_W-1:0]  o_released_cost,
    output logic [tbs_pkg::TOK_W-1:0]  o_tokens_now,
    output logic [CNT_W-1:0]           o_queue_count
);

    typedef struct packed {
        logic                      token_dropped;
        tbs_pkg::t_drop_code       drop_code;
        logic                      released;
        logic [tbs_pkg::ID_W-1:0]  released_id;
        logic [tbs_pkg::TOK_W-1:0] released_cost;
        logic [tbs_pkg::TOK_W-1:0] tokens_now;
        logic [CNT_W-1:0]          queue_count;
    } t_result;

    logic [tbs_pkg::TOK_W-1:0] r_depth;
    logic [tbs_pkg::TOK_W-1:0] r_tokens, n_tokens;
    logic [tbs_pkg::TOK_W-1:0] tok_after;
    logic [CNT_W-1:0]          q_count;
    logic [CNT_W-1:0]          cnt_after_push;
    logic                      accept;
    logic                      is_tick;
    tbs_pkg::t_q_ctrl          q_ctrl;
    tbs_pkg::t_entry           in_entry;
    tbs_pkg::t_entry           q_head;
    t_result                   res;
    t_result                   r_out, r_skid;
    logic                      r_out_valid, r_skid_valid;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_skid_valid;
    assign is_tick    = (i_func == tbs_pkg::FUNC_TICK);
    assign in_entry   = '{id: i_packet_id, cost: i_tokens_required};

    tbs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_entry (in_entry),
        .o_head  (q_head),
        .o_count (q_count)
    );

    always_comb begin
        res           = '0;
        q_ctrl        = '0;
        res.drop_code = tbs_pkg::DROP_NONE;
        tok_after     = r_tokens;
        if (is_tick) begin
            if (r_tokens < r_depth) begin
                tok_after = r_tokens + tbs_pkg::TOK_W'(1);
            end else begin
                res.token_dropped = 1'b1;
            end
        end else begin
            priority if (i_tokens_required > r_depth) begin
                res.drop_code = tbs_pkg::DROP_EXCEEDS;
            end else if (q_count == CNT_W'(QUEUE_DEPTH)) begin
                res.drop_code = tbs_pkg::DROP_FULL;
            end else begin
                q_ctrl.push = accept;
            end
        end
        cnt_after_push = q_count + CNT_W'(q_ctrl.push);
        n_tokens       = tok_after;
        if (cnt_after_push != '0 && q_head.cost <= tok_after) begin
            q_ctrl.pop        = accept;
            res.released      = 1'b1;
            res.released_id   = q_head.id;
            res.released_cost = q_head.cost;
            n_tokens          = tok_after - q_head.cost;
        end
        res.tokens_now  = n_tokens;
        res.queue_count = cnt_after_push - CNT_W'(res.released);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth      <= tbs_pkg::BUCKET_DEPTH_RST;
            r_tokens     <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_depth <= i_cfg_wdata;
            end
            if (accept) begin
                r_tokens <= n_tokens;
            end
            if (!r_out_valid || i_out_ready) begin
                r_out_valid  <= r_skid_valid || accept;
                r_skid_valid <= 1'b0;
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_token_dropped = r_out.token_dropped;
    assign o_drop_code     = r_out.drop_code;
    assign o_released      = r_out.released;
    assign o_released_id   = r_out.released_id;
    assign o_released_cost = r_out.released_cost;
    assign o_tokens_now    = r_out.tokens_now;
    assign o_queue_count   = r_out.queue_count;

endmodule

`default_nettype wire

### rtl/tbs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbs_checker
// Port-level checks for the token bucket shaper, bound to the top level.
// ----------------------------------------------------------------------------
module tbs_checker #(
    parameter int unsigned QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF,
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       o_out_valid,
    input wire                       i_out_ready,
    input wire                       o_token_dropped,
    input wire [1:0]                 o_drop_code,
    input wire                       o_released,
    input wire [tbs_pkg::ID_W-1:0]   o_released_id,
    input wire [tbs_pkg::TOK_W-1:0]  o_released_cost,
    input wire [tbs_pkg::TOK_W-1:0]  o_tokens_now,
    input wire [CNT_W-1:0]           o_queue_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_tokens_now)
            && $stable(o_queue_count) && $stable(o_released_id))
        else $error("result item changed while stalled");

    a_tick_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_dropped |-> o_drop_code == tbs_pkg::DROP_NONE)
        else $error("dropped token with a packet drop code");

    a_no_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_released |-> o_released_id == '0 && o_released_cost == '0)
        else $error("release fields set without a release");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_queue_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind token_bucket_shaper_core tbs_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tbs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_token_dropped (o_token_dropped),
    .o_drop_code     (o_drop_code),
    .o_released      (o_released),
    .o_released_id   (o_released_id),
    .o_released_cost (o_released_cost),
    .o_tokens_now    (o_tokens_now),
    .o_queue_count   (o_queue_count)
);

`default_nettype wire
